### sv/tbbmc_pkg.sv
// ----------------------------------------------------------------------------
// tbbmc_pkg
// Shared types and constants of the two-button brightness and mode controller.
// ----------------------------------------------------------------------------
package tbbmc_pkg;

    localparam int LEVEL_STEPS_DEFAULT = 20;

    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int TIME_W     = 32;
    localparam int PHASE_W    = 16;
    localparam int LEVEL_OUT_W = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_WINDOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAINBOW_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RUNNING_PERIOD  = 3'd5;

    // register reset values
    localparam logic [CFG_W-1:0] RST_DEBOUNCE_TIME   = 16'd50;
    localparam logic [CFG_W-1:0] RST_REPEAT_DELAY    = 16'd300;
    localparam logic [CFG_W-1:0] RST_REPEAT_INTERVAL = 16'd100;
    localparam logic [CFG_W-1:0] RST_DC_WINDOW       = 16'd300;
    localparam logic [CFG_W-1:0] RST_RAINBOW_PERIOD  = 16'd50;
    localparam logic [CFG_W-1:0] RST_RUNNING_PERIOD  = 16'd150;

    // display modes
    localparam logic [1:0] MODE_WHITE   = 2'd0;
    localparam logic [1:0] MODE_RAINBOW = 2'd1;
    localparam logic [1:0] MODE_RUNNING = 2'd2;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_STEP   = 2'd1,
        ACT_DOUBLE = 2'd2
    } key_act_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] repeat_delay;
        logic [CFG_W-1:0] repeat_interval;
        logic [CFG_W-1:0] dc_window;
    } key_cfg_t;

    typedef struct packed {
        logic step;           // sample is handled by the key logic
        logic clear_pending;  // mode step drops any pending click
    } key_ctrl_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic              up_level;
        logic              down_level;
    } in_item_t;

    typedef struct packed {
        logic [1:0]             display_mode;
        logic [LEVEL_OUT_W-1:0] brightness_level;
        logic                   white_refresh;
        logic                   blank_all;
        logic                   frame_due;
        logic [PHASE_W-1:0]     frame_phase;
    } out_item_t;

endpackage

### sv/two_button_brightness_mode_controller.sv
// ----------------------------------------------------------------------------
// two_button_brightness_mode_controller
// Two-key brightness and display-mode controller with frame timing.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one key sample (timestamp, up and down
//   levels). m_valid/m_ready/m_data carry one result per sample: display
//   mode, brightness level, white refresh, blank flag, frame due and phase.
//   cfg_we/cfg_index/cfg_wdata write the six timing registers, one per write;
//   writes to indexes beyond the list are dropped. Write only while idle.
// Result timing and flow:
//   a result appears in the cycle after its sample transfer; one sample per
//   cycle is taken while the receiver keeps m_ready high, set by the single
//   result register after the key and frame logic.
// Reset:
//   aresetn low clears mode, level, key state, phase and frame time and loads
//   the register defaults; no result is pending afterwards.
// Stall:
//   while m_ready is low with a result held, s_ready drops and the result
//   stays in place; a sample is still taken in the cycle the result leaves.
// ----------------------------------------------------------------------------
module two_button_brightness_mode_controller
    import tbbmc_pkg::*;
#(
    parameter int LEVEL_STEPS = LEVEL_STEPS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int LW = $clog2(LEVEL_STEPS + 1);
    localparam logic [LW-1:0] LEVEL_MAX = LW'(LEVEL_STEPS);

    // configuration
    logic [CFG_W-1:0] debounce_reg, delay_reg, interval_reg, window_reg;
    logic [CFG_W-1:0] rainbow_reg, running_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= RST_DEBOUNCE_TIME;
            delay_reg    <= RST_REPEAT_DELAY;
            interval_reg <= RST_REPEAT_INTERVAL;
            window_reg   <= RST_DC_WINDOW;
            rainbow_reg  <= RST_RAINBOW_PERIOD;
            running_reg  <= RST_RUNNING_PERIOD;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DEBOUNCE_TIME:   debounce_reg <= cfg_wdata;
                CFG_REPEAT_DELAY:    delay_reg    <= cfg_wdata;
                CFG_REPEAT_INTERVAL: interval_reg <= cfg_wdata;
                CFG_DC_WINDOW:       window_reg   <= cfg_wdata;
                CFG_RAINBOW_PERIOD:  rainbow_reg  <= cfg_wdata;
                CFG_RUNNING_PERIOD:  running_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    key_cfg_t key_cfg;
    assign key_cfg = '{debounce_time:   debounce_reg,
                       repeat_delay:    delay_reg,
                       repeat_interval: interval_reg,
                       dc_window:       window_reg};

    // block state
    logic [1:0]         mode_reg, mode_next;
    logic [LW-1:0]      level_reg, level_next;
    logic               both_reg, both_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [TIME_W-1:0]  frame_time_reg, frame_time_next;
    logic               m_valid_reg;
    out_item_t          m_data_reg, m_data_next;

    logic        accept;
    logic        up_pressed, down_pressed, both_now, mode_step;
    key_ctrl_t   key_ctrl;
    key_act_t    up_act, down_act;

    assign s_ready      = !m_valid_reg || m_ready;
    assign accept       = s_valid && s_ready;
    assign up_pressed   = !s_data.up_level;
    assign down_pressed = !s_data.down_level;
    assign both_now     = up_pressed && down_pressed;
    assign mode_step    = both_now && !both_reg;

    assign key_ctrl = '{step: accept && !both_now,
                        clear_pending: accept && mode_step};

    tbbmc_key u_up_key (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (key_ctrl),
        .pressed (up_pressed),
        .now     (s_data.time_ms),
        .cfg     (key_cfg),
        .act     (up_act)
    );

    tbbmc_key u_down_key (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (key_ctrl),
        .pressed (down_pressed),
        .now     (s_data.time_ms),
        .cfg     (key_cfg),
        .act     (down_act)
    );

    logic [LW-1:0]          level_mid;
    logic [PHASE_W-1:0]     phase_mid;
    logic [CFG_W-1:0]       period;
    logic [TIME_W-1:0]      since_frame;
    logic                   refresh, blank, due, animated;
    logic [LW+LEVEL_OUT_W-1:0] level_ext;

    assign since_frame = s_data.time_ms - frame_time_reg;

    always_comb begin
        mode_next  = mode_reg;
        level_mid  = level_reg;
        level_next = level_reg;
        both_next  = both_now;
        phase_mid  = phase_reg;
        refresh    = 1'b0;
        blank      = 1'b0;

        if (both_now) begin
            if (mode_step) begin
                mode_next = (mode_reg == MODE_RUNNING) ? MODE_WHITE : mode_reg + 2'd1;
                if (mode_next == MODE_WHITE) begin
                    refresh = 1'b1;
                end else begin
                    phase_mid = '0;
                end
            end
        end else begin
            case (up_act)
                ACT_DOUBLE: level_mid = LEVEL_MAX;
                ACT_STEP:   level_mid = (level_reg < LEVEL_MAX) ? level_reg + 1'b1
                                                                : LEVEL_MAX;
                default:    level_mid = level_reg;
            endcase
            case (down_act)
                ACT_DOUBLE: level_next = '0;
                ACT_STEP:   level_next = (level_mid != '0) ? level_mid - 1'b1 : level_mid;
                default:    level_next = level_mid;
            endcase
            if ((up_act != ACT_NONE || down_act != ACT_NONE) && mode_reg == MODE_WHITE) begin
                refresh = 1'b1;
            end
            if (down_act == ACT_DOUBLE && mode_reg != MODE_WHITE) begin
                blank = 1'b1;
            end
        end

        // frames run on the mode as it stands after key handling
        animated        = (mode_next == MODE_RAINBOW) || (mode_next == MODE_RUNNING);
        period          = (mode_next == MODE_RAINBOW) ? rainbow_reg : running_reg;
        due             = animated && (since_frame >= TIME_W'(period));
        phase_next      = due ? phase_mid + 1'b1 : phase_mid;
        frame_time_next = due ? s_data.time_ms : frame_time_reg;

        level_ext   = {{LEVEL_OUT_W{1'b0}}, level_next};
        m_data_next = '{display_mode:     mode_next,
                        brightness_level: level_ext[LEVEL_OUT_W-1:0],
                        white_refresh:    refresh,
                        blank_all:        blank,
                        frame_due:        due,
                        frame_phase:      due ? phase_mid : '0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_WHITE;
            level_reg      <= '0;
            both_reg       <= 1'b0;
            phase_reg      <= '0;
            frame_time_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg       <= mode_next;
                level_reg      <= level_next;
                both_reg       <= both_next;
                phase_reg      <= phase_next;
                frame_time_reg <= frame_time_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_mode_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != 2'd3)
        else $error("display mode out of range");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LEVEL_MAX)
        else $error("brightness level above full");

    a_phase_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.frame_due) |-> (m_data.frame_phase == '0))
        else $error("frame phase set without due frame");

    a_blank_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.blank_all) |-> (m_data.display_mode != MODE_WHITE))
        else $error("blank in white mode");

    a_frame_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && due) |=> (frame_time_reg == $past(s_data.time_ms)
                             && m_data.frame_due))
        else $error("frame time not captured");

endmodule

### sv/tbbmc_key.sv
// ----------------------------------------------------------------------------
// tbbmc_key
// One key: debounce, auto-repeat and double-click detection with its state.
// ----------------------------------------------------------------------------
module tbbmc_key
    import tbbmc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  key_ctrl_t         ctrl,
    input  logic              pressed,
    input  logic [TIME_W-1:0] now,
    input  key_cfg_t          cfg,
    output key_act_t          act
);

    logic              held_reg, held_next;
    logic              pending_reg, pending_next;
    logic [TIME_W-1:0] release_reg, release_next;
    logic [TIME_W-1:0] repeat_reg, repeat_next;
    logic [TIME_W-1:0] click_reg, click_next;

    logic [TIME_W-1:0] since_release, since_repeat, since_click;
    logic [TIME_W-1:0] click_mid, since_click_mid;
    logic              pending_mid;
    logic              press_ok, repeat_ok, click_ok;

    assign since_release = now - release_reg;
    assign since_repeat  = now - repeat_reg;
    assign since_click   = now - click_reg;

    assign press_ok  = !held_reg && (since_release > TIME_W'(cfg.debounce_time));
    assign repeat_ok = held_reg && (since_repeat > TIME_W'(cfg.repeat_delay));
    assign click_ok  = pending_reg && (since_click <= TIME_W'(cfg.dc_window));

    // release path: record click time, then age it out
    assign pending_mid     = pending_reg | held_reg;
    assign click_mid       = (held_reg && !pending_reg) ? now : click_reg;
    assign since_click_mid = now - click_mid;

    always_comb begin
        act = ACT_NONE;
        if (pressed) begin
            if (press_ok) begin
                act = click_ok ? ACT_DOUBLE : ACT_STEP;
            end else if (repeat_ok) begin
                act = ACT_STEP;
            end
        end
    end

    always_comb begin
        held_next    = held_reg;
        pending_next = pending_reg;
        release_next = release_reg;
        repeat_next  = repeat_reg;
        click_next   = click_reg;
        if (ctrl.clear_pending) begin
            pending_next = 1'b0;
        end else if (ctrl.step) begin
            if (pressed) begin
                if (press_ok) begin
                    held_next   = 1'b1;
                    repeat_next = now;
                    if (click_ok) begin
                        pending_next = 1'b0;
                    end
                end else if (repeat_ok) begin
                    pending_next = 1'b0;
                    repeat_next  = now - (TIME_W'(cfg.repeat_delay)
                                          - TIME_W'(cfg.repeat_interval));
                end
            end else begin
                click_next   = click_mid;
                pending_next = pending_mid &&
                               !(since_click_mid > TIME_W'(cfg.dc_window));
                held_next    = 1'b0;
                release_next = now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= 1'b0;
            pending_reg <= 1'b0;
            release_reg <= '0;
            repeat_reg  <= '0;
            click_reg   <= '0;
        end else begin
            held_reg    <= held_next;
            pending_reg <= pending_next;
            release_reg <= release_next;
            repeat_reg  <= repeat_next;
            click_reg   <= click_next;
        end
    end

    // a counted press leaves the key held
    a_press_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.step && !ctrl.clear_pending && pressed && act != ACT_NONE)
            |=> held_reg)
        else $error("key not held after press or repeat");

    // a double click needs a pending click
    a_double_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (act == ACT_DOUBLE) |-> pending_reg)
        else $error("double click without pending click");

    // a handled release always clears held and stamps the release time
    a_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.step && !ctrl.clear_pending && !pressed)
            |=> (!held_reg && release_reg == $past(now)))
        else $error("release not recorded");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-key brightness and display-mode controller.
// Key samples go in over a valid/ready channel, and a tracker class keeps its
// own copy of the key, mode, level and frame state. Every result is checked
// field by field against that prediction. The run covers directed key
// gestures, random gesture streams under several register settings, receiver
// and sender stalls, and a frame run with a frame on every sample.
// ----------------------------------------------------------------------------
module tb_top;
    import tbbmc_pkg::*;

    localparam int LEVEL_STEPS = LEVEL_STEPS_DEFAULT;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int BURST_ITEMS = 40;

    typedef struct packed {
        logic              held;
        logic              pending;
        logic [TIME_W-1:0] release_seen;
        logic [TIME_W-1:0] rpt_time;
        logic [TIME_W-1:0] click_time;
    } key_track_t;

    class brightness_tracker;
        logic [CFG_W-1:0]   regs [6];
        logic [1:0]         mode;
        int                 level;
        logic               both_down;
        key_track_t         up_key;
        key_track_t         dn_key;
        logic [PHASE_W-1:0] phase;
        logic [TIME_W-1:0]  last_frame;
        out_item_t          pending_results [$];
        int                 errors;

        function new();
            regs[CFG_DEBOUNCE_TIME]   = RST_DEBOUNCE_TIME;
            regs[CFG_REPEAT_DELAY]    = RST_REPEAT_DELAY;
            regs[CFG_REPEAT_INTERVAL] = RST_REPEAT_INTERVAL;
            regs[CFG_DC_WINDOW]       = RST_DC_WINDOW;
            regs[CFG_RAINBOW_PERIOD]  = RST_RAINBOW_PERIOD;
            regs[CFG_RUNNING_PERIOD]  = RST_RUNNING_PERIOD;
            mode       = MODE_WHITE;
            level      = 0;
            both_down  = 1'b0;
            up_key     = '0;
            dn_key     = '0;
            phase      = '0;
            last_frame = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx <= CFG_RUNNING_PERIOD) begin
                regs[idx] = val;
            end
        endfunction

        function key_act_t key_update(inout key_track_t k, input logic pressed,
                                      input logic [TIME_W-1:0] now);
            key_act_t          act;
            logic [TIME_W-1:0] span;
            act  = ACT_NONE;
            span = TIME_W'(regs[CFG_REPEAT_DELAY]) - TIME_W'(regs[CFG_REPEAT_INTERVAL]);
            if (pressed) begin
                if (!k.held && (now - k.release_seen) > TIME_W'(regs[CFG_DEBOUNCE_TIME])) begin
                    k.held     = 1'b1;
                    k.rpt_time = now;
                    if (k.pending && (now - k.click_time) <= TIME_W'(regs[CFG_DC_WINDOW])) begin
                        k.pending = 1'b0;
                        act       = ACT_DOUBLE;
                    end else begin
                        act = ACT_STEP;
                    end
                end else if (k.held && (now - k.rpt_time) > TIME_W'(regs[CFG_REPEAT_DELAY])) begin
                    // auto-repeat drops a pending click, next step one interval on
                    k.pending  = 1'b0;
                    k.rpt_time = now - span;
                    act        = ACT_STEP;
                end
            end else begin
                if (k.held && !k.pending) begin
                    k.pending    = 1'b1;
                    k.click_time = now;
                end
                if (k.pending && (now - k.click_time) > TIME_W'(regs[CFG_DC_WINDOW])) begin
                    k.pending = 1'b0;
                end
                k.held         = 1'b0;
                k.release_seen = now;
            end
            return act;
        endfunction

        // predicts the result of one accepted sample
        function void take_sample(in_item_t it);
            out_item_t        res;
            key_act_t         act;
            logic [CFG_W-1:0] period;
            logic             up_on;
            logic             dn_on;
            up_on = !it.up_level;
            dn_on = !it.down_level;
            res   = '0;
            if (up_on && dn_on) begin
                if (!both_down) begin
                    both_down = 1'b1;
                    mode = (mode == MODE_RUNNING) ? MODE_WHITE : mode + 2'd1;
                    if (mode == MODE_WHITE) begin
                        res.white_refresh = 1'b1;
                    end else begin
                        phase = '0;
                    end
                    up_key.pending = 1'b0;
                    dn_key.pending = 1'b0;
                end
            end else begin
                both_down = 1'b0;
                act = key_update(up_key, up_on, it.time_ms);
                if (act == ACT_DOUBLE) begin
                    level = LEVEL_STEPS;
                end else if (act == ACT_STEP && level < LEVEL_STEPS) begin
                    level++;
                end
                if (act != ACT_NONE && mode == MODE_WHITE) begin
                    res.white_refresh = 1'b1;
                end
                act = key_update(dn_key, dn_on, it.time_ms);
                if (act == ACT_DOUBLE) begin
                    level = 0;
                    if (mode == MODE_WHITE) begin
                        res.white_refresh = 1'b1;
                    end else begin
                        res.blank_all = 1'b1;
                    end
                end else if (act == ACT_STEP) begin
                    if (level > 0) begin
                        level--;
                    end
                    if (mode == MODE_WHITE) begin
                        res.white_refresh = 1'b1;
                    end
                end
            end
            if (mode == MODE_RAINBOW || mode == MODE_RUNNING) begin
                period = (mode == MODE_RAINBOW) ? regs[CFG_RAINBOW_PERIOD]
                                                : regs[CFG_RUNNING_PERIOD];
                if ((it.time_ms - last_frame) >= TIME_W'(period)) begin
                    res.frame_due   = 1'b1;
                    res.frame_phase = phase;
                    phase           = phase + 1'b1;
                    last_frame      = it.time_ms;
                end
            end
            res.display_mode     = mode;
            res.brightness_level = LEVEL_OUT_W'(level);
            pending_results.push_back(res);
        endfunction

        function void field_check(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= 40) begin
                    $error("%s: expected %0d, got %0d", field, want, got);
                end
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 40) begin
                    $error("result with no sample waiting: %h", got);
                end
                return;
            end
            want = pending_results.pop_front();
            field_check("display_mode", 32'(want.display_mode), 32'(got.display_mode));
            field_check("brightness_level", 32'(want.brightness_level),
                        32'(got.brightness_level));
            field_check("white_refresh", 32'(want.white_refresh), 32'(got.white_refresh));
            field_check("blank_all", 32'(want.blank_all), 32'(got.blank_all));
            field_check("frame_due", 32'(want.frame_due), 32'(got.frame_due));
            field_check("frame_phase", 32'(want.frame_phase), 32'(got.frame_phase));
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    brightness_tracker tracker = new();

    logic [TIME_W-1:0] now_ms = '0;
    int unsigned       tick_scale = 120;
    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;
    int                items_sent = 0;
    bit                rx_hold_req = 1'b0;
    int                hold_left = 0;
    int                cycle_count = 0;

    two_button_brightness_mode_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // transfers are taken from the values held just before the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                tracker.check_result(m_data);
            end
            if (s_valid && s_ready) begin
                tracker.take_sample(s_data);
            end
        end
    end

    always @(posedge aclk) begin
        if (rx_hold_req) begin
            hold_left   = 300;
            rx_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_sample(logic [TIME_W-1:0] t, logic up_lv, logic dn_lv);
        int       gap;
        in_item_t it;
        if (items_sent < 300) begin
            tx_idle_pct = 37;
            rx_idle_pct = 79;
        end else if (items_sent < 600) begin
            tx_idle_pct = 79;
            rx_idle_pct = 37;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        if (items_sent == 650) begin
            rx_hold_req = 1'b1;
        end
        gap = 0;
        while (gap < 8 && $urandom_range(99) < tx_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        it.time_ms    = t;
        it.up_level   = up_lv;
        it.down_level = dn_lv;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        now_ms = t;
    endtask

    function automatic logic [TIME_W-1:0] adv();
        int r;
        r = $urandom_range(99);
        if (r < 4) begin
            return $urandom;
        end else if (r < 50) begin
            return $urandom_range(tick_scale);
        end
        return $urandom_range(3 * tick_scale + 2, tick_scale);
    endfunction

    task automatic press_step(logic up_lv, logic dn_lv);
        send_sample(now_ms + adv(), up_lv, dn_lv);
    endtask

    // sender holds off until every result is back
    task automatic pause_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        tracker.write_reg(idx, val);
    endtask

    task automatic load_regs(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] dly,
                             logic [CFG_W-1:0] ivl, logic [CFG_W-1:0] win,
                             logic [CFG_W-1:0] rb, logic [CFG_W-1:0] run);
        // indexes past the list must be dropped
        write_reg(CFG_RUNNING_PERIOD + 3'd1, CFG_W'($urandom));
        write_reg(CFG_RUNNING_PERIOD + 3'd2, CFG_W'($urandom));
        write_reg(CFG_DEBOUNCE_TIME, deb);
        write_reg(CFG_REPEAT_DELAY, dly);
        write_reg(CFG_REPEAT_INTERVAL, ivl);
        write_reg(CFG_DC_WINDOW, win);
        write_reg(CFG_RAINBOW_PERIOD, rb);
        write_reg(CFG_RUNNING_PERIOD, run);
        cfg_we <= 1'b0;
    endtask

    task automatic run_gesture();
        int   kind;
        int   n;
        logic pick_up;
        kind    = $urandom_range(9);
        pick_up = 1'($urandom_range(1));
        n       = $urandom_range(3, 1);
        case (kind)
            0, 1, 2: begin
                press_step(1'b1, 1'b1);
                repeat (n) press_step(!pick_up, pick_up);
                press_step(1'b1, 1'b1);
            end
            3, 4: begin
                repeat (2) begin
                    press_step(1'b1, 1'b1);
                    press_step(!pick_up, pick_up);
                end
                press_step(1'b1, 1'b1);
            end
            5, 6: begin
                press_step(1'b1, 1'b1);
                repeat (n + 3) press_step(!pick_up, pick_up);
                press_step(1'b1, 1'b1);
            end
            7: begin
                repeat (n) press_step(1'b0, 1'b0);
                if ($urandom_range(1)) begin
                    press_step(!pick_up, pick_up);
                end
                press_step(1'b1, 1'b1);
            end
            default: begin
                repeat (n) press_step(1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        endcase
    endtask

    task automatic run_until(int target);
        while (items_sent < target) begin
            run_gesture();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed gestures at reset settings
        send_sample(32'd0,    1'b1, 1'b1);
        send_sample(32'd100,  1'b0, 1'b1);  // up press
        send_sample(32'd500,  1'b0, 1'b1);  // first auto-repeat
        send_sample(32'd601,  1'b0, 1'b1);  // repeat one interval later
        send_sample(32'd700,  1'b1, 1'b1);
        send_sample(32'd760,  1'b0, 1'b1);  // up double click, full level
        send_sample(32'd2000, 1'b1, 1'b1);
        send_sample(32'd2400, 1'b1, 1'b1);  // stale click dropped
        send_sample(32'd2500, 1'b0, 1'b1);  // step clamped at the top
        send_sample(32'd2600, 1'b1, 1'b1);
        send_sample(32'd2700, 1'b1, 1'b0);
        send_sample(32'd2800, 1'b1, 1'b1);
        send_sample(32'd2900, 1'b1, 1'b0);  // down double click in white mode
        send_sample(32'd3000, 1'b1, 1'b1);
        send_sample(32'd3400, 1'b1, 1'b0);  // outside the window, clamped at zero
        send_sample(32'd3450, 1'b1, 1'b1);
        send_sample(32'd3500, 1'b0, 1'b0);  // both keys, rainbow mode
        send_sample(32'd3501, 1'b0, 1'b0);
        send_sample(32'd3600, 1'b1, 1'b1);
        send_sample(32'd3700, 1'b1, 1'b0);
        send_sample(32'd3750, 1'b1, 1'b1);
        send_sample(32'd3850, 1'b1, 1'b0);  // down double click blanks
        send_sample(32'd3900, 1'b0, 1'b0);
        send_sample(32'd4000, 1'b1, 1'b1);
        send_sample(32'd4100, 1'b0, 1'b0);  // back to white
        send_sample(32'd4200, 1'b1, 1'b1);

        tick_scale = 120;
        run_until(200);

        pause_drained();
        load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        now_ms     = 32'hFFFF_FF00;
        tick_scale = 3;
        run_until(360);

        pause_drained();
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        tick_scale = 40000;
        run_until(520);

        pause_drained();
        load_regs(CFG_W'($urandom_range(1000)), CFG_W'($urandom_range(1000)),
                  CFG_W'($urandom_range(1000)), CFG_W'($urandom_range(1000)),
                  CFG_W'($urandom_range(1000)), CFG_W'($urandom_range(1000)));
        tick_scale = 400;
        run_until(700);

        // interval above delay makes the repeat time wrap
        pause_drained();
        load_regs(16'd10, 16'd20, 16'd200, 16'd150, 16'd30, 16'd60);
        tick_scale = 100;
        run_until(800);

        // rainbow run with a frame on every sample
        pause_drained();
        load_regs(16'd10, 16'd20, 16'd200, 16'd150, 16'd0, 16'd0);
        while (tracker.mode != MODE_RAINBOW) begin
            press_step(1'b0, 1'b0);
            press_step(1'b1, 1'b1);
            pause_drained();
        end
        repeat (BURST_ITEMS) begin
            send_sample(now_ms + $urandom_range(3), 1'b1, 1'b1);
        end

        pause_drained();
        if (tracker.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
